/* rtl/core/salz_pkg.sv */
// ----------------------------------------------------------------------------
// salz_pkg: shared types and constants of the suffix match finder
// Command codes, size defaults and the compare-unit status word.
// ----------------------------------------------------------------------------
package salz_pkg;

   localparam int MaxTextDefault = 4096;
   localparam logic [8:0] MIN_MATCH_RESET = 9'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // status of one suffix compare
   typedef struct packed {
      logic done;
      logic a_less;
   } cmp_status_type;

endpackage

/* rtl/core/salz_cmp.sv */
// ----------------------------------------------------------------------------
// salz_cmp: text store and shared suffix compare unit
// Holds the text and compares two suffixes byte by byte (read in C_RD,
// checked in C_CHK), returning the common prefix length and which sorts first.
// ----------------------------------------------------------------------------
module salz_cmp #(
   parameter int MAX_TEXT = salz_pkg::MaxTextDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_TEXT)-1:0]   wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          start,
   input  logic [$clog2(MAX_TEXT)-1:0]   pos_a,
   input  logic [$clog2(MAX_TEXT)-1:0]   pos_b,
   input  logic [$clog2(MAX_TEXT):0]     text_len,
   output salz_pkg::cmp_status_type      status,
   output logic [$clog2(MAX_TEXT):0]     lcp
);
   import salz_pkg::*;

   localparam int AW = $clog2(MAX_TEXT);
   localparam int LW = AW + 1;

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RD   = 3'b010,
      C_CHK  = 3'b100
   } cstate_type;

   cstate_type      state_ff, state_in;
   logic [AW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [LW-1:0]   h_ff, h_in;
   logic [7:0]      mem [MAX_TEXT];
   logic [7:0]      da_ff, db_ff;
   logic [LW-1:0]   ia, ib;

   assign ia = LW'(a_ff) + h_ff;
   assign ib = LW'(b_ff) + h_ff;
   assign lcp = h_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      da_ff <= mem[ia[AW-1:0]];
      db_ff <= mem[ib[AW-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      h_in          = h_ff;
      status.done   = 1'b0;
      status.a_less = 1'b0;
      case (state_ff)
         C_RD: begin
            if (ia == text_len || ib == text_len) begin
               // the suffix that runs out first sorts first
               status.done   = 1'b1;
               status.a_less = (ia == text_len);
               state_in      = C_IDLE;
            end else begin
               state_in = C_CHK;
            end
         end
         C_CHK: begin
            if (da_ff == db_ff) begin
               h_in     = h_ff + 1'b1;
               state_in = C_RD;
            end else begin
               status.done   = 1'b1;
               status.a_less = (da_ff < db_ff);
               state_in      = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
      if (start) begin
         a_in     = pos_a;
         b_in     = pos_b;
         h_in     = '0;
         state_in = C_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      h_ff <= h_in;
   end

endmodule

/* rtl/core/suffix_array_lz77_match_finder.sv */
// ----------------------------------------------------------------------------
// suffix_array_lz77_match_finder: longest previous factor search
// Loads a text and answers match queries for an LZ77 style encoder.
// ----------------------------------------------------------------------------
// Usage: a load word (req_cmd 0) appends req_data_byte to the text unless it
// is full; req_last_byte marks the text complete. A load after a complete
// text starts a new one. A query word (req_cmd 1) names position
// search_start + search_length and returns one rsp word: the longest common
// prefix with an earlier position that is a lexicographic neighbor among the
// earlier suffixes, capped at lookahead_length, and its backward distance.
// A query runs, for each earlier position, an issue step (S_SCAN) and a
// compare in the shared compare unit (S_WAITQ), plus a tie compare
// (S_WAITT) when two candidates on one side share a prefix length, and
// closes in S_FIN; an error query goes straight to S_FIN. req_ready is high
// only between queries. A finished result waits in the rsp register while
// rsp_ready is low; loads are still taken then, a query finishes but holds.
// Reset clears the text, the built flag and sets min_match_length to 3.
// ----------------------------------------------------------------------------
module suffix_array_lz77_match_finder #(
   parameter int MAX_TEXT = salz_pkg::MaxTextDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [11:0] req_search_start,
   input  logic [11:0] req_search_length,
   input  logic [12:0] req_lookahead_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_match_length,
   output logic [11:0] rsp_match_distance,
   output logic        rsp_query_error,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import salz_pkg::*;

   localparam int AW = $clog2(MAX_TEXT);
   localparam int LW = AW + 1;
   localparam int CW = (LW > 13) ? LW : 13;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_WAITQ = 5'b00100,
      S_WAITT = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [8:0]      min_ff;
   logic [LW-1:0]   len_ff, len_in;
   logic            built_ff, built_in;
   logic [AW-1:0]   q_ff, q_in, j_ff, j_in;
   logic [12:0]     look_ff, look_in;
   logic            err_ff, err_in;
   logic            pv_ff, pv_in, nv_ff, nv_in;
   logic [AW-1:0]   pj_ff, pj_in, nj_ff, nj_in;
   logic [LW-1:0]   pl_ff, pl_in, nl_ff, nl_in;
   logic            tie_prev_ff, tie_prev_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [12:0]     rlen_ff, rlen_in;
   logic [11:0]     rdist_ff, rdist_in;
   logic            rerr_ff, rerr_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic            cmp_start;
   logic [AW-1:0]   cmp_a, cmp_b;
   cmp_status_type  cmp_st;
   logic [LW-1:0]   cmp_lcp;

   logic [CW-1:0]   q_full, plx, nlx, sel_len, cap_len, dist_w;
   logic [LW-1:0]   base_len;
   logic            hit, use_next;

   salz_cmp #(.MAX_TEXT(MAX_TEXT)) u_cmp (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_data_byte),
      .start    (cmp_start),
      .pos_a    (cmp_a),
      .pos_b    (cmp_b),
      .text_len (len_ff),
      .status   (cmp_st),
      .lcp      (cmp_lcp)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_length   = rlen_ff;
   assign rsp_match_distance = rdist_ff;
   assign rsp_query_error    = rerr_ff;

   assign q_full   = CW'(req_search_start) + CW'(req_search_length);
   assign base_len = built_ff ? '0 : len_ff;

   // result selection from the two neighbors
   always_comb begin
      plx      = pv_ff ? CW'(pl_ff) : '0;
      nlx      = nv_ff ? CW'(nl_ff) : '0;
      hit      = (pv_ff || nv_ff) && !(plx < CW'(min_ff) && nlx < CW'(min_ff));
      use_next = !pv_ff || (plx < nlx);
      sel_len  = use_next ? nlx : plx;
      cap_len  = (sel_len > CW'(look_ff)) ? CW'(look_ff) : sel_len;
      dist_w   = CW'(q_ff) - CW'(use_next ? nj_ff : pj_ff);
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      built_in     = built_ff;
      q_in         = q_ff;
      j_in         = j_ff;
      look_in      = look_ff;
      err_in       = err_ff;
      pv_in        = pv_ff;
      nv_in        = nv_ff;
      pj_in        = pj_ff;
      nj_in        = nj_ff;
      pl_in        = pl_ff;
      nl_in        = nl_ff;
      tie_prev_in  = tie_prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rlen_in      = rlen_ff;
      rdist_in     = rdist_ff;
      rerr_in      = rerr_ff;
      wr_en        = 1'b0;
      wr_addr      = base_len[AW-1:0];
      cmp_start    = 1'b0;
      cmp_a        = j_ff;
      cmp_b        = q_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  // drop a finished text, append unless full
                  if (base_len < LW'(MAX_TEXT)) begin
                     wr_en  = 1'b1;
                     len_in = base_len + 1'b1;
                  end else begin
                     len_in = base_len;
                  end
                  built_in = req_last_byte;
               end else begin
                  q_in    = q_full[AW-1:0];
                  look_in = req_lookahead_length;
                  j_in    = '0;
                  pv_in   = 1'b0;
                  nv_in   = 1'b0;
                  if (!built_ff || q_full >= CW'(len_ff)) begin
                     err_in   = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     err_in   = 1'b0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (j_ff == q_ff) begin
               state_in = S_FIN;
            end else begin
               cmp_start = 1'b1;
               state_in  = S_WAITQ;
            end
         end
         S_WAITQ: begin
            if (cmp_st.done) begin
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN;
               if (cmp_st.a_less) begin
                  if (!pv_ff || cmp_lcp > pl_ff) begin
                     pv_in = 1'b1;
                     pj_in = j_ff;
                     pl_in = cmp_lcp;
                  end else if (cmp_lcp == pl_ff) begin
                     // same prefix: keep the larger of the two
                     j_in        = j_ff;
                     cmp_start   = 1'b1;
                     cmp_b       = pj_ff;
                     tie_prev_in = 1'b1;
                     state_in    = S_WAITT;
                  end
               end else begin
                  if (!nv_ff || cmp_lcp > nl_ff) begin
                     nv_in = 1'b1;
                     nj_in = j_ff;
                     nl_in = cmp_lcp;
                  end else if (cmp_lcp == nl_ff) begin
                     j_in        = j_ff;
                     cmp_start   = 1'b1;
                     cmp_b       = nj_ff;
                     tie_prev_in = 1'b0;
                     state_in    = S_WAITT;
                  end
               end
            end
         end
         S_WAITT: begin
            if (cmp_st.done) begin
               if (tie_prev_ff && !cmp_st.a_less) begin
                  pj_in = j_ff;
               end
               if (!tie_prev_ff && cmp_st.a_less) begin
                  nj_in = j_ff;
               end
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FIN: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rerr_in      = err_ff;
               if (err_ff || !hit) begin
                  rlen_in  = '0;
                  rdist_in = '0;
               end else begin
                  rlen_in  = cap_len[12:0];
                  rdist_in = dist_w[11:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_ff       <= MIN_MATCH_RESET;
         len_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
      end
      q_ff        <= q_in;
      j_ff        <= j_in;
      look_ff     <= look_in;
      err_ff      <= err_in;
      pv_ff       <= pv_in;
      nv_ff       <= nv_in;
      pj_ff       <= pj_in;
      nj_ff       <= nj_in;
      pl_ff       <= pl_in;
      nl_ff       <= nl_in;
      tie_prev_ff <= tie_prev_in;
      rlen_ff     <= rlen_in;
      rdist_ff    <= rdist_in;
      rerr_ff     <= rerr_in;
   end

endmodule

/* rtl/core/salz_checker.sv */
// ----------------------------------------------------------------------------
// salz_checker: port-level checks of the suffix match finder
// Watches the rsp channel and the result encoding over time.
// ----------------------------------------------------------------------------
module salz_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [12:0] rsp_match_length,
   input logic [11:0] rsp_match_distance,
   input logic        rsp_query_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_length)
         && $stable(rsp_match_distance) && $stable(rsp_query_error))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_query_error |->
         rsp_match_length == 13'd0 && rsp_match_distance == 12'd0)
      else $error("error word carries a match");

   a_len_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_length != 13'd0 |-> rsp_match_distance != 12'd0)
      else $error("match without distance");

endmodule

bind suffix_array_lz77_match_finder salz_checker u_salz_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_match_length   (rsp_match_length),
   .rsp_match_distance (rsp_match_distance),
   .rsp_query_error    (rsp_query_error)
);
